@@ rtl/adstwr_pkg.sv @@
// Shared widths, codes and derived sizes for the ADS-TWR initiator block.
// No dependencies; every other file imports this package.
`default_nettype none

package adstwr_pkg;

	// Fractional bits of the time-of-flight result
	localparam int TOF_FRAC_BITS = 8;

	// Field widths
	localparam int OP_W     = 2;
	localparam int TS_W     = 40;
	localparam int TIME_W   = 32;
	localparam int SEQ_W    = 8;
	localparam int ACT_W    = 2;
	localparam int RES_W    = 32;
	localparam int SCALE_W  = 24;
	localparam int MUL_W    = 32;

	localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd307390;

	// Event codes (op field); code 3 behaves as a timeout
	localparam logic [OP_W-1:0] OP_ACK     = 2'd0;
	localparam logic [OP_W-1:0] OP_FINAL   = 2'd1;
	localparam logic [OP_W-1:0] OP_TIMEOUT = 2'd2;

	// Action codes
	localparam logic [ACT_W-1:0] ACT_RANGE   = 2'd0;
	localparam logic [ACT_W-1:0] ACT_DONE    = 2'd1;
	localparam logic [ACT_W-1:0] ACT_RESTART = 2'd2;

	// Datapath sizes
	localparam int SUM_W      = TIME_W + 2;               // sum of four intervals
	localparam int PROD_W     = 2 * MUL_W;
	localparam int NUM_W      = PROD_W + TOF_FRAC_BITS;   // dividend
	localparam int QUO_W      = TIME_W + 1 + TOF_FRAC_BITS; // quotient bound
	localparam int Q_HI_W     = QUO_W - MUL_W;
	localparam int DIST_SHIFT = 16 + TOF_FRAC_BITS;
	localparam int DPROD_W    = QUO_W + SCALE_W;
	localparam int DIV_CNT_W  = $clog2(NUM_W + 1);

endpackage

`default_nettype wire

@@ rtl/adstwr_if.sv @@
// Valid/ready channel interfaces for receive events and ranging results.
// Depends on adstwr_pkg for field widths.
`default_nettype none

interface adstwr_evt_if;
	import adstwr_pkg::*;

	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   op;
	logic [TS_W-1:0]   local_tx_time;
	logic [TS_W-1:0]   local_rx_time;
	logic [TIME_W-1:0] remote_time_a;
	logic [TIME_W-1:0] remote_time_b;

	modport source (output valid, op, local_tx_time, local_rx_time,
		remote_time_a, remote_time_b, input ready);
	modport sink (input valid, op, local_tx_time, local_rx_time,
		remote_time_a, remote_time_b, output ready);
endinterface

interface adstwr_res_if;
	import adstwr_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [ACT_W-1:0]        action;
	logic [SEQ_W-1:0]        sequence_number;
	logic signed [RES_W-1:0] tof_ticks_q8;
	logic signed [RES_W-1:0] distance_mm;

	modport source (output valid, action, sequence_number, tof_ticks_q8,
		distance_mm, input ready);
	modport sink (input valid, action, sequence_number, tof_ticks_q8,
		distance_mm, output ready);
endinterface

`default_nettype wire

@@ rtl/adstwr_div.sv @@
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on adstwr_pkg for operand widths.
`default_nettype none

module adstwr_div (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         start,
	input  wire [adstwr_pkg::NUM_W-1:0] numer,
	input  wire [adstwr_pkg::SUM_W-1:0] denom,
	output logic                        done,
	output logic [adstwr_pkg::QUO_W-1:0] quot
);
	import adstwr_pkg::*;

	logic [NUM_W-1:0]     num_q;   // dividend bits shift out, quotient bits shift in
	logic [SUM_W-1:0]     rem_q;
	logic [SUM_W-1:0]     den_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 done_q;

	logic [SUM_W:0] rem_sh;
	logic [SUM_W:0] rem_sub;
	logic           ge;

	// one restoring step
	always_comb begin
		rem_sh  = {rem_q, num_q[NUM_W-1]};
		rem_sub = rem_sh - {1'b0, den_q};
		ge      = rem_sh >= {1'b0, den_q};
	end

	// step counter and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= DIV_CNT_W'(NUM_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= numer;
			rem_q <= '0;
			den_q <= denom;
		end else if (cnt_q != '0) begin
			num_q <= {num_q[NUM_W-2:0], ge};
			rem_q <= ge ? rem_sub[SUM_W-1:0] : rem_sh[SUM_W-1:0];
		end
	end

	assign done = done_q;
	assign quot = num_q[QUO_W-1:0];

endmodule

`default_nettype wire

@@ rtl/ads_twr_initiator_ranging.sv @@
// Top level of the ADS-TWR initiator: event decode, shared 32x32 multiplier
// and sequencer. Depends on adstwr_pkg, adstwr_if and adstwr_div.
`default_nettype none

// Channel    Dir  Word                                         Handshake
// rx_event   in   op, local tx/rx time, remote times a/b       valid/ready
// result     out  action, sequence number, tof q8, distance   valid/ready
// cfg        in   distance_scale_q16                           cfg_we, no ready
//
// ACK, timeout and unmatched FINAL words go from idle straight to output.
// A matched FINAL passes through 2 multiplies, subtract, absolute value,
// a bit-serial restoring division, 2 more multiplies for the distance,
// and final saturation. With all intervals zero the division and the
// distance steps are skipped and a matched FINAL yields zero results.
// rx_event.ready is high only while no word is in work; one finished result
// may wait in the output register while the next word is accepted.
// Reset is asynchronous; no clearing pass.

module ads_twr_initiator_ranging (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           cfg_we,
	input  wire [adstwr_pkg::SCALE_W-1:0] cfg_wdata,
	adstwr_evt_if.sink                    rx_event,
	adstwr_res_if.source                  result
);
	import adstwr_pkg::*;

	typedef enum logic [9:0] {
		ST_IDLE   = 10'b00_0000_0001,
		ST_MUL_A  = 10'b00_0000_0010,
		ST_MUL_B  = 10'b00_0000_0100,
		ST_SUB    = 10'b00_0000_1000,
		ST_ABS    = 10'b00_0001_0000,
		ST_DIV    = 10'b00_0010_0000,
		ST_MUL_LO = 10'b00_0100_0000,
		ST_MUL_HI = 10'b00_1000_0000,
		ST_FIN    = 10'b01_0000_0000,
		ST_OUT    = 10'b10_0000_0000
	} state_t;

	state_t state_q, state_d;

	// configuration and exchange state
	logic [SCALE_W-1:0] scale_q;
	logic               have_ack_q;
	logic [SEQ_W-1:0]   seq_q;
	logic [TIME_W-1:0]  poll_tx_q;
	logic [TIME_W-1:0]  poll_rx_remote_q;
	logic [TIME_W-1:0]  ack_rx_q;

	// work registers
	logic [TIME_W-1:0] round1_q, round2_q, reply1_q, reply2_q;
	logic [SUM_W-1:0]  sum_q;
	logic [PROD_W-1:0] prod_q;   // shared multiplier output register
	logic [PROD_W-1:0] hold_q;   // earlier product
	logic [PROD_W:0]   diff_q;   // pa - pb, top bit is the sign
	logic [ACT_W-1:0]  res_action_q;
	logic [RES_W-1:0]  res_tof_q, res_dist_q;

	// output register
	logic              out_valid_q;
	logic [ACT_W-1:0]  out_action_q;
	logic [SEQ_W-1:0]  out_seq_q;
	logic [RES_W-1:0]  out_tof_q, out_dist_q;

	logic in_acc, out_free, final_ok;
	logic [MUL_W-1:0]  mul_x, mul_y;
	logic [PROD_W-1:0] mul_p;
	logic [PROD_W:0]   neg_diff;
	logic [PROD_W-1:0] abs_mag;
	logic              div_start, div_done;
	logic [NUM_W-1:0]  div_numer;
	logic [QUO_W-1:0]  quot;
	logic [DPROD_W-1:0] dprod;
	logic [DPROD_W-DIST_SHIFT-1:0] dmag;

	// signed saturation of a magnitude to 32 bits
	function automatic logic [RES_W-1:0] sat32(input logic [63:0] mag, input logic neg);
		logic [63:0] nm;
		nm = ~mag + 64'd1;
		if (neg) begin
			sat32 = (mag >= 64'h8000_0000) ? 32'h8000_0000 : nm[RES_W-1:0];
		end else begin
			sat32 = (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[RES_W-1:0];
		end
	endfunction

	assign rx_event.ready = (state_q == ST_IDLE);
	assign in_acc   = rx_event.valid && rx_event.ready;
	assign out_free = !out_valid_q || result.ready;
	assign final_ok = (rx_event.op == OP_FINAL) && have_ack_q;

	// shared multiplier operand select
	always_comb begin
		case (state_q)
			ST_MUL_A: begin
				mul_x = round1_q;
				mul_y = round2_q;
			end
			ST_MUL_B: begin
				mul_x = reply1_q;
				mul_y = reply2_q;
			end
			ST_MUL_LO: begin
				mul_x = quot[MUL_W-1:0];
				mul_y = MUL_W'(scale_q);
			end
			ST_MUL_HI: begin
				mul_x = MUL_W'(quot[QUO_W-1:MUL_W]);
				mul_y = MUL_W'(scale_q);
			end
			default: begin
				mul_x = '0;
				mul_y = '0;
			end
		endcase
	end
	assign mul_p = mul_x * mul_y;

	// magnitude of the product difference, feeds the divider
	assign neg_diff  = -diff_q;
	assign abs_mag   = diff_q[PROD_W] ? neg_diff[PROD_W-1:0] : diff_q[PROD_W-1:0];
	assign div_numer = NUM_W'(abs_mag) << TOF_FRAC_BITS;
	assign div_start = (state_q == ST_ABS) && (sum_q != '0);

	adstwr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.numer  (div_numer),
		.denom  (sum_q),
		.done   (div_done),
		.quot   (quot)
	);

	// distance: high partial product in prod_q, low one in hold_q
	assign dprod = (DPROD_W'(prod_q) << MUL_W) + DPROD_W'(hold_q);
	assign dmag  = dprod[DPROD_W-1:DIST_SHIFT];

	// sequencer next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					state_d = final_ok ? ST_MUL_A : ST_OUT;
				end
			end
			ST_MUL_A:  state_d = ST_MUL_B;
			ST_MUL_B:  state_d = ST_SUB;
			ST_SUB:    state_d = ST_ABS;
			ST_ABS:    state_d = (sum_q == '0) ? ST_OUT : ST_DIV;
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_MUL_LO;
				end
			end
			ST_MUL_LO: state_d = ST_MUL_HI;
			ST_MUL_HI: state_d = ST_FIN;
			ST_FIN:    state_d = ST_OUT;
			ST_OUT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	// control state, configuration and exchange state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_IDLE;
			scale_q          <= SCALE_RESET;
			have_ack_q       <= 1'b0;
			seq_q            <= '0;
			poll_tx_q        <= '0;
			poll_rx_remote_q <= '0;
			ack_rx_q         <= '0;
			out_valid_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				scale_q <= cfg_wdata;
			end
			if (in_acc) begin
				seq_q <= seq_q + 1'b1;
				if (rx_event.op == OP_ACK) begin
					poll_tx_q        <= rx_event.local_tx_time[TIME_W-1:0];
					poll_rx_remote_q <= rx_event.remote_time_a;
					ack_rx_q         <= rx_event.local_rx_time[TIME_W-1:0];
					have_ack_q       <= 1'b1;
				end else begin
					have_ack_q <= 1'b0;
				end
			end
			if ((state_q == ST_OUT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				round1_q <= ack_rx_q - poll_tx_q;
				round2_q <= rx_event.remote_time_b - rx_event.remote_time_a;
				reply1_q <= rx_event.remote_time_a - poll_rx_remote_q;
				reply2_q <= rx_event.local_tx_time[TIME_W-1:0] - ack_rx_q;
				res_tof_q  <= '0;
				res_dist_q <= '0;
				if (rx_event.op == OP_ACK) begin
					res_action_q <= ACT_RANGE;
				end else if (final_ok) begin
					res_action_q <= ACT_DONE;
				end else begin
					res_action_q <= ACT_RESTART;
				end
			end
			ST_MUL_A: begin
				prod_q <= mul_p;
				sum_q  <= SUM_W'(round1_q) + SUM_W'(round2_q)
					+ SUM_W'(reply1_q) + SUM_W'(reply2_q);
			end
			ST_MUL_B, ST_MUL_HI: begin
				hold_q <= prod_q;
				prod_q <= mul_p;
			end
			ST_SUB: begin
				diff_q <= {1'b0, hold_q} - {1'b0, prod_q};
			end
			ST_MUL_LO: begin
				prod_q <= mul_p;
			end
			ST_FIN: begin
				res_tof_q  <= sat32(64'(quot), diff_q[PROD_W]);
				res_dist_q <= sat32(64'(dmag), diff_q[PROD_W]);
			end
			ST_OUT: begin
				if (out_free) begin
					out_action_q <= res_action_q;
					out_seq_q    <= seq_q;
					out_tof_q    <= res_tof_q;
					out_dist_q   <= res_dist_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign result.valid           = out_valid_q;
	assign result.action          = out_action_q;
	assign result.sequence_number = out_seq_q;
	assign result.tof_ticks_q8    = $signed(out_tof_q);
	assign result.distance_mm     = $signed(out_dist_q);

endmodule

`default_nettype wire
